### hdl/bb3_pkg.sv
`timescale 1ns / 1ps
package bb3_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT);

  localparam int unsigned CFG_W_W    = 11;
  localparam int unsigned CFG_H_W    = 13;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 2'd1;

  localparam logic [CFG_W_W-1:0] CFG_W_RESET = 11'd1024;
  localparam logic [CFG_H_W-1:0] CFG_H_RESET = 13'd768;

  localparam int unsigned CH_W   = 8;
  localparam int unsigned PIX_W  = 3 * CH_W;
  localparam int unsigned SUM_W  = 12;
  localparam int unsigned NUM_W  = SUM_W + 1;
  localparam int unsigned CNT_W  = 4;
  localparam int unsigned RCP_SHIFT = 18;
  localparam int unsigned RCP_W  = 18;
  localparam int unsigned PROD_W = NUM_W + RCP_W;

  // reciprocal of 2n, scaled by 2^RCP_SHIFT and rounded up; exact for x < 2^13
  localparam int unsigned RCP_N1 = (2**RCP_SHIFT + 1) / 2;
  localparam int unsigned RCP_N2 = (2**RCP_SHIFT + 3) / 4;
  localparam int unsigned RCP_N3 = (2**RCP_SHIFT + 5) / 6;
  localparam int unsigned RCP_N4 = (2**RCP_SHIFT + 7) / 8;
  localparam int unsigned RCP_N6 = (2**RCP_SHIFT + 11) / 12;
  localparam int unsigned RCP_N9 = (2**RCP_SHIFT + 17) / 18;

  // channel 2 = red, 1 = green, 0 = blue
  typedef logic [2:0][CH_W-1:0] pix_t;
  typedef pix_t [8:0]           win_t;

  typedef struct packed {
    logic       sum_en;
    logic       mul_en;
    logic [8:0] cell_mask;
  } avg_ctrl_t;

  function automatic logic [RCP_W-1:0] recip(input logic [CNT_W-1:0] n);
    logic [RCP_W-1:0] r;
    r = RCP_W'(RCP_N9);
    case (n)
      4'd1:    r = RCP_W'(RCP_N1);
      4'd2:    r = RCP_W'(RCP_N2);
      4'd3:    r = RCP_W'(RCP_N3);
      4'd4:    r = RCP_W'(RCP_N4);
      4'd6:    r = RCP_W'(RCP_N6);
      default: r = RCP_W'(RCP_N9);
    endcase
    return r;
  endfunction

endpackage

### hdl/bb3_ram.sv
`timescale 1ns / 1ps
module bb3_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/bb3_avg.sv
`timescale 1ns / 1ps
// Masked 3x3 sum, then (2*sum+n)/(2n) by reciprocal multiply. Two register stages.
module bb3_avg (
  input  logic               clk_i,
  input  bb3_pkg::avg_ctrl_t ctrl_i,
  input  bb3_pkg::win_t      win_i,
  output bb3_pkg::pix_t      mean_o
);

  logic [2:0][bb3_pkg::SUM_W-1:0]  sum_d;
  logic [bb3_pkg::CNT_W-1:0]       cnt_d;
  logic [2:0][bb3_pkg::NUM_W-1:0]  num_d, num_q;
  logic [bb3_pkg::RCP_W-1:0]       rcp_q;
  logic [2:0][bb3_pkg::PROD_W-1:0] prod_d, prod_q;

  always_comb begin
    sum_d = '0;
    cnt_d = '0;
    for (int k = 0; k < 9; k++) begin
      if (ctrl_i.cell_mask[k]) begin
        cnt_d = cnt_d + 4'd1;
        for (int c = 0; c < 3; c++) begin
          sum_d[c] = sum_d[c] + {4'b0, win_i[k][c]};
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      num_d[c] = {sum_d[c], 1'b0} + {9'b0, cnt_d};
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod_d[c] = {{bb3_pkg::RCP_W{1'b0}}, num_q[c]} * {{bb3_pkg::NUM_W{1'b0}}, rcp_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      num_q <= num_d;
      rcp_q <= bb3_pkg::recip(cnt_d);
    end
    if (ctrl_i.mul_en) begin
      prod_q <= prod_d;
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mean_o[c] = prod_q[c][bb3_pkg::RCP_SHIFT +: bb3_pkg::CH_W];
    end
  end

endmodule

### hdl/box_blur_3x3_edge_aware.sv
`timescale 1ns / 1ps
// Each accepted input beat runs the row-store update, then the sum, multiply and emit states
//   once per result it causes (0..4); the single shared average unit (sum stage, multiply
//   stage) handles one result at a time; the next input beat waits for the last result.
// Reset: async active low; clears position, window, sequencer and output valid, and loads
//   width 1024, height 768. Row stores are not cleared; they are written before use.
module box_blur_3x3_edge_aware (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // pixel input
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [7:0]                        red_i,
  input  logic [7:0]                        green_i,
  input  logic [7:0]                        blue_i,
  // result output
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [7:0]                        blur_red_o,
  output logic [7:0]                        blur_green_o,
  output logic [7:0]                        blur_blue_o,
  output logic [11:0]                       out_row_o,
  output logic [9:0]                        out_col_o,
  output logic                              run_last_o,
  output logic                              frame_done_o,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [bb3_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_READ = 5'b00010,
    S_SUM  = 5'b00100,
    S_MUL  = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration, clamped to the legal frame size
  logic [bb3_pkg::CFG_W_W-1:0] cfg_w_q;
  logic [bb3_pkg::CFG_H_W-1:0] cfg_h_q;
  logic [bb3_pkg::CFG_W_W-1:0] w_dec;
  logic [bb3_pkg::CFG_H_W-1:0] h_dec;
  logic [bb3_pkg::COL_W-1:0]   w_m1;
  logic [bb3_pkg::ROW_W-1:0]   h_m1;

  // position of the next input pixel
  logic [bb3_pkg::ROW_W-1:0] row_q, row_d;
  logic [bb3_pkg::COL_W-1:0] col_q, col_d;

  // item in flight: its pixel, position and outstanding results
  bb3_pkg::pix_t             pix_q;
  logic [bb3_pkg::ROW_W-1:0] i_q;
  logic [bb3_pkg::COL_W-1:0] j_q;
  logic [3:0]                pend_q, pend_d;

  bb3_pkg::win_t win_q;

  logic [bb3_pkg::PIX_W-1:0] older_rd, prior_rd;

  logic in_beat, out_free, rd_phase, emit_load;

  // result selection
  logic [1:0] sel;
  logic [3:0] sel_oh;
  logic       sel_last;
  logic [2:0] row_inc, col_inc;
  bb3_pkg::avg_ctrl_t avg_ctrl;
  bb3_pkg::pix_t      mean;

  // output register
  logic                      out_valid_q;
  bb3_pkg::pix_t             out_pix_q;
  logic [11:0]               out_row_q;
  logic [9:0]                out_col_q;
  logic                      out_last_q, out_done_q;

  // effective size: zero acts as one, oversize acts as max
  assign w_dec = cfg_w_q - 11'd1;
  assign h_dec = cfg_h_q - 13'd1;

  always_comb begin
    if (cfg_w_q == '0) begin
      w_m1 = '0;
    end else if (cfg_w_q > bb3_pkg::CFG_W_W'(bb3_pkg::MAX_WIDTH)) begin
      w_m1 = bb3_pkg::COL_W'(bb3_pkg::MAX_WIDTH - 1);
    end else begin
      w_m1 = w_dec[bb3_pkg::COL_W-1:0];
    end
    if (cfg_h_q == '0) begin
      h_m1 = '0;
    end else if (cfg_h_q > bb3_pkg::CFG_H_W'(bb3_pkg::MAX_HEIGHT)) begin
      h_m1 = bb3_pkg::ROW_W'(bb3_pkg::MAX_HEIGHT - 1);
    end else begin
      h_m1 = h_dec[bb3_pkg::ROW_W-1:0];
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign in_beat    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign rd_phase   = (state_q == S_READ);
  assign emit_load  = (state_q == S_EMIT) && out_free;

  // raster advance with wrap at row and frame end
  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (in_beat) begin
      if (col_q == w_m1) begin
        col_d = '0;
        row_d = (row_q == h_m1) ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  // Row stores: read at accept, rotate and write back the following cycle.
  // Next read of any column comes only after that write has landed, so no forwarding.
  bb3_ram #(
    .WIDTH (bb3_pkg::PIX_W),
    .DEPTH (bb3_pkg::MAX_WIDTH)
  ) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (rd_phase),
    .waddr_i (j_q),
    .wdata_i (prior_rd),
    .re_i    (in_beat),
    .raddr_i (col_q),
    .rdata_o (older_rd)
  );

  bb3_ram #(
    .WIDTH (bb3_pkg::PIX_W),
    .DEPTH (bb3_pkg::MAX_WIDTH)
  ) u_prior_ram (
    .clk_i   (clk_i),
    .we_i    (rd_phase),
    .waddr_i (j_q),
    .wdata_i (pix_q),
    .re_i    (in_beat),
    .raddr_i (col_q),
    .rdata_o (prior_rd)
  );

  // Pending results, bit order: above-left, above-right edge, bottom-left, bottom-right.
  always_comb begin
    sel = 2'd3;
    for (int k = 3; k >= 0; k--) begin
      if (pend_q[k]) begin
        sel = 2'(k);
      end
    end
    sel_oh   = 4'b0001 << sel;
    sel_last = ((pend_q & ~sel_oh) == '0);
  end

  // Window cells that lie in the frame and around the selected center.
  // Right-edge and bottom-row results drop the far column / row of the window.
  assign row_inc = {1'b1, (i_q != '0), (i_q >= 2) && !sel[1]};
  assign col_inc = {1'b1, (j_q != '0), (j_q >= 2) && !sel[0]};

  always_comb begin
    avg_ctrl.sum_en = (state_q == S_SUM);
    avg_ctrl.mul_en = (state_q == S_MUL);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        avg_ctrl.cell_mask[r*3+c] = row_inc[r] && col_inc[c];
      end
    end
  end

  bb3_avg u_avg (
    .clk_i  (clk_i),
    .ctrl_i (avg_ctrl),
    .win_i  (win_q),
    .mean_o (mean)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    case (state_q)
      S_IDLE: begin
        if (in_beat) begin
          pend_d[0] = (row_q != '0) && (col_q != '0);
          pend_d[1] = (row_q != '0) && (col_q == w_m1);
          pend_d[2] = (row_q == h_m1) && (col_q != '0);
          pend_d[3] = (row_q == h_m1) && (col_q == w_m1);
          state_d   = S_READ;
        end
      end
      S_READ: begin
        state_d = (pend_q != '0) ? S_SUM : S_IDLE;
      end
      S_SUM: begin
        state_d = S_MUL;
      end
      S_MUL: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          pend_d  = pend_q & ~sel_oh;
          state_d = sel_last ? S_IDLE : S_SUM;
        end
      end
      default: begin
        state_d = S_IDLE;
        pend_d  = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pend_q      <= '0;
      row_q       <= '0;
      col_q       <= '0;
      cfg_w_q     <= bb3_pkg::CFG_W_RESET;
      cfg_h_q     <= bb3_pkg::CFG_H_RESET;
      win_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      if (cfg_we_i) begin
        // any register write restarts the frame
        if (cfg_idx_i == bb3_pkg::CFG_IDX_WIDTH) begin
          cfg_w_q <= cfg_data_i[bb3_pkg::CFG_W_W-1:0];
          row_q   <= '0;
          col_q   <= '0;
          win_q   <= '0;
        end else if (cfg_idx_i == bb3_pkg::CFG_IDX_HEIGHT) begin
          cfg_h_q <= cfg_data_i;
          row_q   <= '0;
          col_q   <= '0;
          win_q   <= '0;
        end
      end else begin
        row_q <= row_d;
        col_q <= col_d;
        if (rd_phase) begin
          // shift left; new right column is older row, prior row, new pixel
          for (int r = 0; r < 3; r++) begin
            win_q[r*3+0] <= win_q[r*3+1];
            win_q[r*3+1] <= win_q[r*3+2];
          end
          win_q[2] <= older_rd;
          win_q[5] <= prior_rd;
          win_q[8] <= pix_q;
        end
      end
      if (emit_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      pix_q <= {red_i, green_i, blue_i};
      i_q   <= row_q;
      j_q   <= col_q;
    end
    if (emit_load) begin
      out_pix_q  <= mean;
      out_row_q  <= sel[1] ? i_q : i_q - 1'b1;
      out_col_q  <= sel[0] ? j_q : j_q - 1'b1;
      out_last_q <= sel_last;
      out_done_q <= (sel == 2'd3);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign blur_red_o   = out_pix_q[2];
  assign blur_green_o = out_pix_q[1];
  assign blur_blue_o  = out_pix_q[0];
  assign out_row_o    = out_row_q;
  assign out_col_o    = out_col_q;
  assign run_last_o   = out_last_q;
  assign frame_done_o = out_done_q;

  // the average unit only runs while a result is outstanding
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SUM || state_q == S_MUL || state_q == S_EMIT) |-> (pend_q != '0))
    else $error("average unit busy with no pending result");

  // an accepted beat always goes to the row-store update next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> (state_q == S_READ))
    else $error("row-store update skipped after input beat");

  // the frame's final result ends its input's run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_done_o) |-> run_last_o)
    else $error("frame_done without run_last");

  // position stays inside the effective frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(cfg_we_i) == 1'b0 |-> (col_q <= w_m1) && (row_q <= h_m1))
    else $error("position outside frame");

endmodule

### tb/box_blur_checker.sv
`timescale 1ns / 1ps
module box_blur_checker
  import bb3_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [7:0]            red_i,
  input  logic [7:0]            green_i,
  input  logic [7:0]            blue_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic [7:0]            blur_red_i,
  input  logic [7:0]            blur_green_i,
  input  logic [7:0]            blur_blue_i,
  input  logic [11:0]           out_row_i,
  input  logic [9:0]            out_col_i,
  input  logic                  run_last_i,
  input  logic                  frame_done_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           pending_o,
  output int unsigned           errors_o
);

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] row;
    logic [9:0]  col;
    logic        run_last;
    logic        frame_done;
  } blur_beat_t;

  blur_beat_t         due_blurs[$];
  pix_t               older_row_q [MAX_WIDTH];
  pix_t               prior_row_q [MAX_WIDTH];
  pix_t               win_q [9];
  logic [CFG_W_W-1:0] width_q;
  logic [CFG_H_W-1:0] height_q;
  int unsigned        row_q;
  int unsigned        col_q;

  // rounded-half-up mean over the in-frame cells around window cell (cr, cc)
  function automatic blur_beat_t neighborhood_mean(input int cr, input int cc,
                                                   input logic [2:0] row_ok,
                                                   input logic [2:0] col_ok,
                                                   input int unsigned row,
                                                   input int unsigned col,
                                                   input logic done);
    int unsigned sum [3];
    int unsigned n;
    blur_beat_t  b;
    sum = '{0, 0, 0};
    n = 0;
    for (int wr = cr - 1; wr <= cr + 1; wr++) begin
      if (wr >= 0 && wr <= 2 && row_ok[wr]) begin
        for (int wc = cc - 1; wc <= cc + 1; wc++) begin
          if (wc >= 0 && wc <= 2 && col_ok[wc]) begin
            for (int ch = 0; ch < 3; ch++) sum[ch] += win_q[wr * 3 + wc][ch];
            n++;
          end
        end
      end
    end
    b.red        = 8'((2 * sum[2] + n) / (2 * n));
    b.green      = 8'((2 * sum[1] + n) / (2 * n));
    b.blue       = 8'((2 * sum[0] + n) / (2 * n));
    b.row        = 12'(row);
    b.col        = 10'(col);
    b.run_last   = 1'b0;
    b.frame_done = done;
    return b;
  endfunction

  function automatic int unsigned field_bad(input string name, input logic [11:0] want,
                                            input logic [11:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : predict
    blur_beat_t  want;
    blur_beat_t  batch[$];
    int unsigned w;
    int unsigned h;
    int unsigned i;
    int unsigned j;
    logic [2:0]  row_ok;
    logic [2:0]  col_ok;
    logic        restart;
    pix_t        px;
    if (!rst_ni) begin
      width_q  = CFG_W_RESET;
      height_q = CFG_H_RESET;
      row_q    = 0;
      col_q    = 0;
      foreach (win_q[k]) win_q[k] = '0;
      foreach (older_row_q[k]) begin
        older_row_q[k] = '0;
        prior_row_q[k] = '0;
      end
      due_blurs.delete();
      errors_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_blurs.size() == 0) begin
          $error("result beat at row %0d col %0d with nothing expected", out_row_i, out_col_i);
          errors_o++;
        end else begin
          want = due_blurs.pop_front();
          errors_o += field_bad("blur_red", 12'(want.red), 12'(blur_red_i))
                    + field_bad("blur_green", 12'(want.green), 12'(blur_green_i))
                    + field_bad("blur_blue", 12'(want.blue), 12'(blur_blue_i))
                    + field_bad("out_row", want.row, out_row_i)
                    + field_bad("out_col", 12'(want.col), 12'(out_col_i))
                    + field_bad("run_last", 12'(want.run_last), 12'(run_last_i))
                    + field_bad("frame_done", 12'(want.frame_done), 12'(frame_done_i));
        end
      end

      if (cfg_we_i) begin
        restart = 1'b0;
        case (cfg_idx_i)
          CFG_IDX_WIDTH: begin
            width_q = cfg_data_i[CFG_W_W-1:0];
            restart = 1'b1;
          end
          CFG_IDX_HEIGHT: begin
            height_q = cfg_data_i[CFG_H_W-1:0];
            restart = 1'b1;
          end
          default: ;
        endcase
        if (restart) begin
          row_q = 0;
          col_q = 0;
          foreach (win_q[k]) win_q[k] = '0;
        end
      end

      if (in_valid_i && in_ready_i) begin
        w = (width_q == 0) ? 1 : ((width_q > MAX_WIDTH) ? MAX_WIDTH : width_q);
        h = (height_q == 0) ? 1 : ((height_q > MAX_HEIGHT) ? MAX_HEIGHT : height_q);
        i = (row_q >= h) ? 0 : row_q;
        j = (col_q >= w) ? 0 : col_q;
        px = {red_i, green_i, blue_i};

        for (int r = 0; r < 3; r++) begin
          win_q[r * 3]     = win_q[r * 3 + 1];
          win_q[r * 3 + 1] = win_q[r * 3 + 2];
        end
        win_q[2] = older_row_q[j];
        win_q[5] = prior_row_q[j];
        win_q[8] = px;
        older_row_q[j] = prior_row_q[j];
        prior_row_q[j] = px;

        row_ok = {1'b1, i >= 1, i >= 2};
        col_ok = {1'b1, j >= 1, j >= 2};
        batch.delete();
        if (i >= 1 && j >= 1)
          batch.push_back(neighborhood_mean(1, 1, row_ok, col_ok, i - 1, j - 1, 1'b0));
        if (i >= 1 && j == w - 1)
          batch.push_back(neighborhood_mean(1, 2, row_ok, col_ok, i - 1, j, 1'b0));
        if (i == h - 1 && j >= 1)
          batch.push_back(neighborhood_mean(2, 1, row_ok, col_ok, i, j - 1, 1'b0));
        if (i == h - 1 && j == w - 1)
          batch.push_back(neighborhood_mean(2, 2, row_ok, col_ok, i, j, 1'b1));
        if (batch.size() > 0) batch[batch.size() - 1].run_last = 1'b1;
        foreach (batch[k]) due_blurs.push_back(batch[k]);

        j++;
        if (j >= w) begin
          j = 0;
          i++;
          if (i >= h) i = 0;
        end
        row_q = i;
        col_q = j;
      end
    end
    pending_o = due_blurs.size();
  end

endmodule

### tb/box_blur_3x3_edge_aware_test.sv
`timescale 1ns / 1ps
module box_blur_3x3_edge_aware_test;
  import bb3_pkg::*;

  // drain time after the last predicted result so the block can finish; leaves margin
  localparam int unsigned DRAIN_CYCLES  = 20;
  // cycles without any beat or register write before the run is called hung
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RANDOM_PIXELS = 70;

  // indexes past the two registers; writes there must not disturb the frame
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  pix_valid = 1'b0;
  logic [7:0]            red       = '0;
  logic [7:0]            green     = '0;
  logic [7:0]            blue      = '0;
  logic                  res_ready = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx   = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  wire                   pix_ready;
  wire                   res_valid;
  wire  [7:0]            blur_red;
  wire  [7:0]            blur_green;
  wire  [7:0]            blur_blue;
  wire  [11:0]           out_row;
  wire  [9:0]            out_col;
  wire                   run_last;
  wire                   frame_done;

  int unsigned           pending;
  int unsigned           errors;

  // per-phase switches: when set, that side starts no new idle stretch
  bit                    src_steady   = 1'b0;
  bit                    sink_steady  = 1'b0;
  int unsigned           sink_hold    = 0;
  int unsigned           quiet_cycles = 0;

  always #5 clk = ~clk;

  box_blur_3x3_edge_aware dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (pix_valid),
    .in_ready_o  (pix_ready),
    .red_i       (red),
    .green_i     (green),
    .blue_i      (blue),
    .out_valid_o (res_valid),
    .out_ready_i (res_ready),
    .blur_red_o  (blur_red),
    .blur_green_o(blur_green),
    .blur_blue_o (blur_blue),
    .out_row_o   (out_row),
    .out_col_o   (out_col),
    .run_last_o  (run_last),
    .frame_done_o(frame_done),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  // watches both channels and the register port, predicts every result beat
  box_blur_checker u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (pix_valid),
    .in_ready_i  (pix_ready),
    .red_i       (red),
    .green_i     (green),
    .blue_i      (blue),
    .out_valid_i (res_valid),
    .out_ready_i (res_ready),
    .blur_red_i  (blur_red),
    .blur_green_i(blur_green),
    .blur_blue_i (blur_blue),
    .out_row_i   (out_row),
    .out_col_i   (out_col),
    .run_last_i  (run_last),
    .frame_done_i(frame_done),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .pending_o   (pending),
    .errors_o    (errors)
  );

  // random idle stretch length, usually from the lower of two ranges
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // result side: random back-pressure unless the phase asks for a steady sink
  always @(posedge clk) begin : sink
    int unsigned len;
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      res_ready <= 1'b0;
    end else if (!sink_steady && $urandom_range(0, 99) < 25) begin
      len = idle_len();
      sink_hold <= len - 1;
      res_ready <= 1'b0;
    end else begin
      res_ready <= 1'b1;
    end
  end

  // hang detection: any beat or register write resets the count
  always @(posedge clk) begin
    if (rst_n) begin
      if ((pix_valid && pix_ready) || (res_valid && res_ready) || cfg_we) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // All tasks below start and end right at a rising edge.

  // Offer one pixel beat, after an optional gap, and hold it until taken.
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    int unsigned gap;
    gap = 0;
    if (!src_steady && $urandom_range(0, 99) < 30) gap = idle_len();
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_valid <= 1'b1;
    red       <= r;
    green     <= g;
    blue      <= b;
    do @(posedge clk); while (!pix_ready);
  endtask

  // patterned beats hit 0x00/0xFF in red, 0x01/0xFF in green, a ramp in blue
  task automatic feed_pixels(input int unsigned count, input bit patterned);
    for (int unsigned k = 0; k < count; k++) begin
      if (patterned)
        send_pixel(k[0] ? 8'hFF : 8'h00, (k % 3 == 0) ? 8'hFF : 8'h01, 8'(127 + k));
      else
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  // Wait until every predicted beat has come out, then give the block time to
  // finish pixels that produce nothing. pending is read on the falling edge so
  // the checker has already settled for this cycle.
  task automatic settle_block();
    pix_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  // one phase: new frame size, a run of pixels, drain
  task automatic run_frame(input logic [CFG_DATA_W-1:0] w_data,
                           input logic [CFG_DATA_W-1:0] h_data,
                           input int unsigned count, input bit patterned);
    src_steady  <= ($urandom_range(0, 3) == 0);
    sink_steady <= ($urandom_range(0, 3) == 0);
    cfg_write(CFG_IDX_WIDTH, w_data);
    cfg_write(CFG_IDX_HEIGHT, h_data);
    feed_pixels(count, patterned);
    settle_block();
  endtask

  initial begin : stimulus
    int unsigned fed;
    int unsigned w;
    int unsigned h;
    int unsigned count;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset size is 1024x768: a few beats produce no result yet.
    feed_pixels(3, 1'b1);
    settle_block();

    // 3x3 frame covers corner, edge and full-window divisors. Width data has
    // stray bits above the register that must be dropped. Halfway through,
    // writes to the unused indexes must leave the frame position alone.
    cfg_write(CFG_IDX_WIDTH, 13'h1803);
    cfg_write(CFG_IDX_HEIGHT, 13'd3);
    feed_pixels(4, 1'b1);
    settle_block();
    cfg_write(CFG_IDX_SPARE_A, 13'($urandom));
    cfg_write(CFG_IDX_SPARE_B, 13'h1FFF);
    feed_pixels(5, 1'b1);
    settle_block();

    // Zero sizes act as 1: every pixel is its own frame (wrap after frame end).
    run_frame(13'd0, 13'd0, 2, 1'b1);
    // Single column and single row: divisors 2 and 3.
    run_frame(13'd1, 13'd3, 3, 1'b1);
    run_frame(13'd3, 13'd1, 3, 1'b1);

    // Largest legal sizes, only a short partial frame.
    run_frame(13'd1024, 13'd4096, 6, 1'b0);
    // Oversized width acts as 1024: a short run along one row.
    run_frame(13'h1FFF, 13'd1, 16, 1'b0);
    // Oversized height with zero width: one column, height acts as 4096.
    run_frame(13'd0, 13'h1FFF, 40, 1'b0);

    // Random small frames, one full frame plus up to one more each.
    fed = 0;
    while (fed < RANDOM_PIXELS) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      count = w * h + $urandom_range(0, w * h);
      run_frame({2'($urandom), 11'(w)}, 13'(h), count, 1'b0);
      fed += count;
    end

    @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

### files.f
hdl/bb3_pkg.sv
hdl/bb3_ram.sv
hdl/bb3_avg.sv
hdl/box_blur_3x3_edge_aware.sv
tb/box_blur_checker.sv
tb/box_blur_3x3_edge_aware_test.sv
